FILE: rtl/core/audio_peak_bin_decimator_assert.svh
// assertion macros for the peak bin decimator
// used by audio_peak_bin_decimator.sv, no other dependencies
`ifndef AUDIO_PEAK_BIN_DECIMATOR_ASSERT_SVH
`define AUDIO_PEAK_BIN_DECIMATOR_ASSERT_SVH

// same-cycle implication
`define APBD_ASSERT_IMPL(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define APBD_ASSERT_NEXT(lbl, ck, rs, ante, cons, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) else $error(msg);

`endif

FILE: rtl/core/apbd_pkg.sv
// shared types, widths and helper functions for the peak bin decimator
// no dependencies
package apbd_pkg;

  localparam int MAX_BINS   = 2048;
  localparam int MAX_FRAMES = 4194304;

  localparam int SAMPLE_W   = 16;
  localparam int REM_W      = $clog2(MAX_BINS);
  localparam int BINS_W     = REM_W + 1;
  localparam int FC_W       = $clog2(MAX_FRAMES);
  localparam int FRAMES_W   = FC_W + 1;
  localparam int CH_W       = 2;
  localparam int DIV_CNT_W  = $clog2(FRAMES_W);
  localparam int PADDR_W    = 4;
  localparam int PDATA_W    = 32;

  typedef enum logic [1:0] {
    REG_NUM_BINS      = 2'd0,
    REG_TOTAL_FRAMES  = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIV_IDLE,
    DIV_RUN,
    DIV_DONE
  } div_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef struct packed {
    logic [REM_W-1:0]    bin_index;
    logic [SAMPLE_W-1:0] peak_left;
    logic [SAMPLE_W-1:0] peak_right;
    logic                last_bin;
  } result_t;

  function automatic logic [FRAMES_W-1:0] eff_frames(input logic [FRAMES_W-1:0] t);
    logic [FRAMES_W-1:0] v;
    v = t;
    if (v == '0) v = FRAMES_W'(1);
    if (v > FRAMES_W'(MAX_FRAMES)) v = FRAMES_W'(MAX_FRAMES);
    return v;
  endfunction

  function automatic logic [BINS_W-1:0] eff_bins(input logic [BINS_W-1:0] nb,
                                                 input logic [FRAMES_W-1:0] t);
    logic [BINS_W-1:0] e;
    e = nb;
    if (e == '0) e = BINS_W'(1);
    if (e > BINS_W'(MAX_BINS)) e = BINS_W'(MAX_BINS);
    if (FRAMES_W'(e) > t) e = t[BINS_W-1:0];
    return e;
  endfunction

endpackage

FILE: rtl/core/apbd_lane.sv
// one channel lane: sample magnitude and running peak of the open bin
// depends on apbd_pkg
module apbd_lane import apbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                restart,
  input  logic                accept,
  input  logic                active,
  input  logic                close,
  input  logic [SAMPLE_W-1:0] sample,
  output logic [SAMPLE_W-1:0] peak
);

  logic [SAMPLE_W-1:0] running;
  logic [SAMPLE_W-1:0] mag;

  always_comb begin
    mag = sample[SAMPLE_W-1] ? (~sample + SAMPLE_W'(1)) : sample;
    if (accept && active && (mag > running)) begin
      peak = mag;
    end else begin
      peak = running;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      running <= '0;
    end else if (accept) begin
      running <= close ? '0 : peak;
    end
  end

endmodule

FILE: rtl/core/apbd_div.sv
// restoring divider, one quotient bit per cycle, for bin length and remainder
// depends on apbd_pkg
module apbd_div import apbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [FRAMES_W-1:0] dividend,
  input  logic [BINS_W-1:0]   divisor,
  output logic [FRAMES_W-1:0] quotient,
  output logic [REM_W-1:0]    remainder,
  output div_status_t         status
);

  div_state_t            state;
  div_state_t            state_next;
  logic [FRAMES_W-1:0]   work;
  logic [REM_W-1:0]      rem;
  logic [BINS_W-1:0]     div_e;
  logic [DIV_CNT_W-1:0]  cnt;
  logic [BINS_W-1:0]     shifted;
  logic [BINS_W-1:0]     diff;
  logic                  ge;

  assign shifted = {rem, work[FRAMES_W-1]};
  assign ge      = shifted >= div_e;
  assign diff    = shifted - div_e;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DIV_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    status     = '{busy: 1'b0, done: 1'b0};
    unique case (state)
      DIV_IDLE: begin
        if (start) state_next = DIV_RUN;
      end
      DIV_RUN: begin
        status.busy = 1'b1;
        if (start) begin
          state_next = DIV_RUN;
        end else if (cnt == DIV_CNT_W'(FRAMES_W - 1)) begin
          state_next = DIV_DONE;
        end
      end
      DIV_DONE: begin
        status.busy = 1'b1;
        status.done = 1'b1;
        state_next  = start ? DIV_RUN : DIV_IDLE;
      end
      default: state_next = DIV_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (start) begin
      cnt <= '0;
    end else if (state == DIV_RUN) begin
      cnt <= cnt + DIV_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work  <= dividend;
      rem   <= '0;
      div_e <= divisor;
    end else if (state == DIV_RUN) begin
      work <= {work[FRAMES_W-2:0], ge};
      rem  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
    end
  end

  assign quotient  = work;
  assign remainder = rem;

endmodule

FILE: rtl/core/audio_peak_bin_decimator.sv
// Peak-per-bin decimator for a 16-bit PCM record.
// Input channel: one stereo frame (sample_left, sample_right) per beat, moved
// when sample_valid is high and sample_stall is low.
// Output channel: one beat per closed bin (bin_index, peak_left, peak_right,
// last_bin), moved when bin_valid is high and bin_stall is low.
// Registers over the APB-style port: num_bins at 0x0, total_frames at 0x4,
// channel_count at 0x8. A write to a mapped register restarts the record.
// Throughput: one frame per cycle while sample_stall is low. A bin result is
// registered into the output register, or into the skid stage when bin_stall
// holds the output. Two lanes (left, right) track the peaks; the bin counter
// stage merges them into the result. After every mapped register write the
// bin length and remainder are recomputed by a one-bit-per-cycle divider.
// Reset: registers take num_bins=100, total_frames=1, channel_count=1 and
// the block takes frames on the first cycle after reset.
// When bin_stall holds a result, one more result is caught in a skid stage;
// sample_stall rises while that skid stage is occupied or the divider is busy.
// Depends on apbd_pkg, apbd_lane, apbd_div and the assertion header.
`include "audio_peak_bin_decimator_assert.svh"

module audio_peak_bin_decimator import apbd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready,
  input  logic                sample_valid,
  output logic                sample_stall,
  input  logic [SAMPLE_W-1:0] sample_left,
  input  logic [SAMPLE_W-1:0] sample_right,
  output logic                bin_valid,
  input  logic                bin_stall,
  output logic [REM_W-1:0]    bin_index,
  output logic [SAMPLE_W-1:0] peak_left,
  output logic [SAMPLE_W-1:0] peak_right,
  output logic                last_bin
);

  logic [BINS_W-1:0]   num_bins;
  logic [FRAMES_W-1:0] total_frames;
  logic [CH_W-1:0]     channel_count;

  logic [FC_W-1:0]     frame_counter;
  logic [REM_W-1:0]    bin_counter;
  logic [FRAMES_W-1:0] next_boundary;
  logic [REM_W-1:0]    boundary_remainder;
  logic [FRAMES_W-1:0] bin_len;
  logic [REM_W-1:0]    bin_rem;
  logic                start_pending;

  logic [FRAMES_W-1:0] eff_t;
  logic [BINS_W-1:0]   eff_e;
  logic                stereo;
  logic                cfg_wr;
  logic                cfg_hit;
  reg_idx_t            cfg_idx;

  logic [FRAMES_W-1:0] div_q;
  logic [REM_W-1:0]    div_r;
  div_status_t         div_st;
  logic                busy;
  logic                accept;

  logic [FRAMES_W-1:0] fc;
  logic                close;
  logic                last;
  logic [BINS_W-1:0]   rem_sum;
  logic [REM_W-1:0]    rem_next;
  logic                step;
  logic [FRAMES_W-1:0] boundary_next;
  logic [SAMPLE_W-1:0] lane_peak_left;
  logic [SAMPLE_W-1:0] lane_peak_right;

  result_t             res_new;
  result_t             out_res;
  result_t             skid_res;
  logic                out_valid;
  logic                skid_valid;
  logic                out_free;

  // register port
  assign pready  = 1'b1;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign cfg_wr  = psel && penable && pwrite;

  always_comb begin
    prdata  = '0;
    cfg_hit = 1'b0;
    unique case (cfg_idx)
      REG_NUM_BINS: begin
        prdata  = PDATA_W'(num_bins);
        cfg_hit = 1'b1;
      end
      REG_TOTAL_FRAMES: begin
        prdata  = PDATA_W'(total_frames);
        cfg_hit = 1'b1;
      end
      REG_CHANNEL_COUNT: begin
        prdata  = PDATA_W'(channel_count);
        cfg_hit = 1'b1;
      end
      default: begin
        prdata  = '0;
        cfg_hit = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      num_bins      <= BINS_W'(100);
      total_frames  <= FRAMES_W'(1);
      channel_count <= CH_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_NUM_BINS:      num_bins      <= pwdata[BINS_W-1:0];
        REG_TOTAL_FRAMES:  total_frames  <= pwdata[FRAMES_W-1:0];
        REG_CHANNEL_COUNT: channel_count <= pwdata[CH_W-1:0];
        default: ;
      endcase
    end
  end

  assign eff_t  = eff_frames(total_frames);
  assign eff_e  = eff_bins(num_bins, eff_t);
  assign stereo = channel_count[CH_W-1];

  // bin length and remainder
  apbd_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (start_pending),
    .dividend  (eff_t),
    .divisor   (eff_e),
    .quotient  (div_q),
    .remainder (div_r),
    .status    (div_st)
  );

  assign busy         = start_pending || div_st.busy;
  assign sample_stall = busy || skid_valid;
  assign accept       = sample_valid && !sample_stall;

  // channel lanes
  apbd_lane u_lane_left (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr && cfg_hit),
    .accept  (accept),
    .active  (1'b1),
    .close   (close),
    .sample  (sample_left),
    .peak    (lane_peak_left)
  );

  apbd_lane u_lane_right (
    .clk     (clk),
    .rst     (rst),
    .restart (cfg_wr && cfg_hit),
    .accept  (accept),
    .active  (stereo),
    .close   (close),
    .sample  (sample_right),
    .peak    (lane_peak_right)
  );

  // bin boundary tracking
  always_comb begin
    fc            = FRAMES_W'(frame_counter) + FRAMES_W'(1);
    close         = fc >= next_boundary;
    last          = (BINS_W'(bin_counter) + BINS_W'(1)) >= eff_e;
    rem_sum       = BINS_W'(boundary_remainder) + BINS_W'(bin_rem);
    rem_next      = (rem_sum >= eff_e) ? REM_W'(rem_sum - eff_e) : rem_sum[REM_W-1:0];
    step          = (BINS_W'(rem_next) + BINS_W'(bin_rem)) >= eff_e;
    boundary_next = next_boundary + bin_len + FRAMES_W'(step);
    res_new.bin_index  = bin_counter;
    res_new.peak_left  = lane_peak_left;
    res_new.peak_right = stereo ? lane_peak_right : '0;
    res_new.last_bin   = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_pending      <= 1'b0;
      frame_counter      <= '0;
      bin_counter        <= '0;
      boundary_remainder <= '0;
      next_boundary      <= FRAMES_W'(1);
      bin_len            <= FRAMES_W'(1);
      bin_rem            <= '0;
    end else if (cfg_wr && cfg_hit) begin
      start_pending      <= 1'b1;
      frame_counter      <= '0;
      bin_counter        <= '0;
      boundary_remainder <= '0;
    end else begin
      start_pending <= 1'b0;
      if (div_st.done) begin
        bin_len       <= div_q;
        bin_rem       <= div_r;
        next_boundary <= div_q;
      end else if (accept) begin
        if (close && last) begin
          frame_counter      <= '0;
          bin_counter        <= '0;
          boundary_remainder <= '0;
          next_boundary      <= bin_len;
        end else if (close) begin
          frame_counter      <= fc[FC_W-1:0];
          bin_counter        <= bin_counter + REM_W'(1);
          boundary_remainder <= rem_next;
          next_boundary      <= boundary_next;
        end else begin
          frame_counter <= fc[FC_W-1:0];
        end
      end
    end
  end

  // output register and skid stage
  assign out_free = !out_valid || !bin_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= accept && close;
      end
    end else if (accept && close) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_res <= skid_res;
      end else if (accept && close) begin
        out_res <= res_new;
      end
    end else if (accept && close) begin
      skid_res <= res_new;
    end
  end

  assign bin_valid  = out_valid;
  assign bin_index  = out_res.bin_index;
  assign peak_left  = out_res.peak_left;
  assign peak_right = out_res.peak_right;
  assign last_bin   = out_res.last_bin;

  `APBD_ASSERT_IMPL(a_skid_behind_out, clk, rst, skid_valid, out_valid, "skid beat without output beat")
  `APBD_ASSERT_NEXT(a_held_goes_to_skid, clk, rst, accept && close && !out_free, skid_valid, "result lost while output held")
  `APBD_ASSERT_IMPL(a_rem_in_range, clk, rst, !busy, BINS_W'(boundary_remainder) < eff_e, "boundary remainder out of range")
  `APBD_ASSERT_IMPL(a_bin_in_range, clk, rst, !busy, BINS_W'(bin_counter) < eff_e, "bin counter beyond bin count")

endmodule

FILE: tb/sv/tb_top.sv
// self-checking bench for audio_peak_bin_decimator: queued PCM frames, random idling,
// per-bin peak prediction checked against every bin beat
// depends on apbd_pkg and the rtl top level
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import apbd_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int SETTLE_CYCLES = 4;
  localparam int END_CYCLES    = 20;
  localparam int RANDOM_FRAMES = 400;
  localparam logic [PADDR_W-1:0] ADDR_UNMAPPED = PADDR_W'(12);

  typedef struct packed {
    logic [SAMPLE_W-1:0] left;
    logic [SAMPLE_W-1:0] right;
  } frame_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  logic [SAMPLE_W-1:0] sample_left = '0;
  logic [SAMPLE_W-1:0] sample_right = '0;
  logic                bin_valid;
  logic                bin_stall = 1'b0;
  logic [REM_W-1:0]    bin_index;
  logic [SAMPLE_W-1:0] peak_left;
  logic [SAMPLE_W-1:0] peak_right;
  logic                last_bin;

  frame_t      frame_queue[$];
  result_t     pending_bins[$];
  frame_t      next_frame;
  result_t     want_bin;
  int          frames_pushed = 0;
  int          frames_taken = 0;
  int          mismatches = 0;
  int unsigned cycle_count = 0;
  int          sender_idle_pct = 7;
  int          receiver_stall_pct = 80;

  // predicted block state
  logic [11:0] reg_bins;
  logic [22:0] reg_frames;
  logic [1:0]  reg_chan;
  int unsigned frame_cnt;
  int unsigned bin_cnt;
  int unsigned boundary;
  int unsigned rem_acc;
  int unsigned peak_l;
  int unsigned peak_r;

  audio_peak_bin_decimator dut (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .sample_valid(sample_valid), .sample_stall(sample_stall),
    .sample_left(sample_left), .sample_right(sample_right),
    .bin_valid(bin_valid), .bin_stall(bin_stall),
    .bin_index(bin_index), .peak_left(peak_left), .peak_right(peak_right),
    .last_bin(last_bin)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int unsigned record_frames();
    int unsigned t;
    t = reg_frames;
    if (t == 0) t = 1;
    if (t > MAX_FRAMES) t = MAX_FRAMES;
    return t;
  endfunction

  function automatic int unsigned record_bins();
    int unsigned e;
    int unsigned t;
    e = reg_bins;
    t = record_frames();
    if (e == 0) e = 1;
    if (e > MAX_BINS) e = MAX_BINS;
    if (e > t) e = t;
    return e;
  endfunction

  function automatic int unsigned magnitude(logic [SAMPLE_W-1:0] s);
    int unsigned v;
    v = s;
    return s[SAMPLE_W-1] ? 32'h10000 - v : v;
  endfunction

  function automatic logic [PADDR_W-1:0] reg_addr(reg_idx_t idx);
    return {idx, 2'b00};
  endfunction

  task automatic clear_record();
    frame_cnt = 0;
    bin_cnt = 0;
    rem_acc = 0;
    boundary = record_frames() / record_bins();
    peak_l = 0;
    peak_r = 0;
  endtask

  task automatic track_frame(frame_t f);
    bit          stereo;
    int unsigned t;
    int unsigned e;
    int unsigned q;
    int unsigned r;
    int unsigned ml;
    int unsigned mr;
    int unsigned fc;
    result_t     beat;
    stereo = reg_chan >= 2;
    t = record_frames();
    e = record_bins();
    q = t / e;
    r = t % e;
    ml = magnitude(f.left);
    if (ml > peak_l) peak_l = ml;
    if (stereo) begin
      mr = magnitude(f.right);
      if (mr > peak_r) peak_r = mr;
    end
    fc = frame_cnt + 1;
    if (fc < boundary) begin
      frame_cnt = fc;
      return;
    end
    beat.bin_index  = bin_cnt[REM_W-1:0];
    beat.peak_left  = peak_l[SAMPLE_W-1:0];
    beat.peak_right = stereo ? peak_r[SAMPLE_W-1:0] : '0;
    beat.last_bin   = (bin_cnt + 1 >= e);
    pending_bins.push_back(beat);
    if (beat.last_bin) begin
      clear_record();
      return;
    end
    frame_cnt = fc;
    bin_cnt = bin_cnt + 1;
    rem_acc = rem_acc + r;
    if (rem_acc >= e) rem_acc = rem_acc - e;
    boundary = boundary + q + ((rem_acc + r >= e) ? 1 : 0);
    peak_l = 0;
    peak_r = 0;
  endtask

  task automatic write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
    bit mapped;
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    mapped = 1'b1;
    if (addr == reg_addr(REG_NUM_BINS)) reg_bins = data[11:0];
    else if (addr == reg_addr(REG_TOTAL_FRAMES)) reg_frames = data[22:0];
    else if (addr == reg_addr(REG_CHANNEL_COUNT)) reg_chan = data[1:0];
    else mapped = 1'b0;
    if (mapped) clear_record();
  endtask

  task automatic push_frame(logic [SAMPLE_W-1:0] l, logic [SAMPLE_W-1:0] r);
    frame_queue.push_back('{left: l, right: r});
    frames_pushed++;
  endtask

  function automatic logic [SAMPLE_W-1:0] rand_sample();
    logic [SAMPLE_W-1:0] s;
    case ($urandom_range(9))
      0: s = 16'h8000;
      1: s = 16'h7FFF;
      2: s = 16'h0000;
      3: s = 16'hFFFF;
      4, 5: begin
        s = SAMPLE_W'($urandom_range(15));
        if ($urandom_range(1)) s = -s;
      end
      default: s = SAMPLE_W'($urandom());
    endcase
    return s;
  endfunction

  task automatic push_random(int n);
    repeat (n) push_frame(rand_sample(), rand_sample());
  endtask

  task automatic wait_drain();
    while (frames_taken != frames_pushed || pending_bins.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        track_frame('{left: sample_left, right: sample_right});
        frames_taken++;
      end
      if (!sample_valid || !sample_stall) begin
        if (frame_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          next_frame = frame_queue.pop_front();
          sample_valid <= 1'b1;
          sample_left <= next_frame.left;
          sample_right <= next_frame.right;
        end else begin
          sample_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      bin_stall <= 1'b0;
    end else begin
      bin_stall <= ($urandom_range(99) < receiver_stall_pct);
      if (bin_valid && !bin_stall) begin
        if (pending_bins.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected bin beat: index %0d peak %0d/%0d last %0b",
                     bin_index, peak_left, peak_right, last_bin);
        end else begin
          want_bin = pending_bins.pop_front();
          if (want_bin.bin_index !== bin_index || want_bin.peak_left !== peak_left ||
              want_bin.peak_right !== peak_right || want_bin.last_bin !== last_bin) begin
            mismatches++;
            if (mismatches <= 10)
              $display("bin mismatch: expected index %0d peak %0d/%0d last %0b, got %0d %0d/%0d %0b",
                       want_bin.bin_index, want_bin.peak_left, want_bin.peak_right,
                       want_bin.last_bin, bin_index, peak_left, peak_right, last_bin);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    int          rand_pushed;
    int          n;
    int          half;
    int unsigned t_eff;
    logic [11:0] nb;
    logic [22:0] tf;
    logic [1:0]  ch;
    reg_bins = 12'd100;
    reg_frames = 23'd1;
    reg_chan = 2'd1;
    clear_record();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset settings: one frame per record, mono
    push_frame(16'h8000, 16'h0005);
    push_frame(16'h7FFF, 16'h8000);
    push_frame(16'h0000, 16'h0000);
    push_frame(16'hFFFF, 16'h0001);
    settle();
    write_reg(reg_addr(REG_CHANNEL_COUNT), 32'd2);
    push_frame(16'h8000, 16'h8000);
    push_frame(16'h7FFF, 16'h7FFF);
    push_frame(16'h0001, 16'hFFFF);
    settle();
    // uneven bins 2,2,3 with channel count 3
    write_reg(reg_addr(REG_CHANNEL_COUNT), 32'd3);
    write_reg(reg_addr(REG_NUM_BINS), 32'd3);
    write_reg(reg_addr(REG_TOTAL_FRAMES), 32'd7);
    push_frame(16'h0010, 16'hFFF0);
    push_frame(16'hFF00, 16'h0100);
    push_frame(16'h8000, 16'h0000);
    push_frame(16'h0003, 16'h7FFF);
    push_frame(16'h0000, 16'h0000);
    push_frame(16'h5555, 16'hAAAA);
    push_frame(16'hFFFF, 16'h0002);
    settle();
    // zero registers act as one, channel count zero is mono
    write_reg(reg_addr(REG_CHANNEL_COUNT), 32'd0);
    write_reg(reg_addr(REG_NUM_BINS), 32'd0);
    write_reg(reg_addr(REG_TOTAL_FRAMES), 32'd0);
    push_frame(16'h8001, 16'h8000);
    settle();
    // oversized bin count, limited to the frame count
    write_reg(reg_addr(REG_NUM_BINS), 32'hFFFF_FFFF);
    write_reg(reg_addr(REG_TOTAL_FRAMES), 32'd3);
    write_reg(reg_addr(REG_CHANNEL_COUNT), 32'd2);
    push_frame(16'h1234, 16'h8000);
    push_frame(16'h8000, 16'h4321);
    push_frame(16'h7FFE, 16'h0001);
    settle();
    // unmapped write mid record leaves the record running
    write_reg(reg_addr(REG_NUM_BINS), 32'd2);
    write_reg(reg_addr(REG_TOTAL_FRAMES), 32'd6);
    push_frame(16'h0100, 16'h0200);
    push_frame(16'hFE00, 16'h0300);
    settle();
    write_reg(ADDR_UNMAPPED, 32'hFFFF_FFFF);
    push_frame(16'h0001, 16'h8000);
    push_frame(16'h7FFF, 16'h0000);
    push_frame(16'h0000, 16'h0004);
    push_frame(16'hFFFB, 16'h0005);
    settle();

    // saturated bin count, limited to the frame count
    write_reg(reg_addr(REG_NUM_BINS), 32'hABCD_EFFF);
    write_reg(reg_addr(REG_TOTAL_FRAMES), 32'd40);
    write_reg(reg_addr(REG_CHANNEL_COUNT), 32'd1);
    push_random(40);
    settle();
    // saturated frame count, long open bin
    write_reg(reg_addr(REG_NUM_BINS), 32'h5555_57FF);
    write_reg(reg_addr(REG_TOTAL_FRAMES), 32'hFFFF_FFFF);
    write_reg(reg_addr(REG_CHANNEL_COUNT), 32'h0000_0002);
    push_random(60);
    settle();

    rand_pushed = 0;
    while (rand_pushed < RANDOM_FRAMES) begin
      if (rand_pushed < RANDOM_FRAMES / 3) begin
        sender_idle_pct = 7;
        receiver_stall_pct = 80;
      end else if (rand_pushed < 2 * RANDOM_FRAMES / 3) begin
        sender_idle_pct = 80;
        receiver_stall_pct = 7;
      end else begin
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
      end
      settle();
      if ($urandom_range(5) == 0) write_reg(ADDR_UNMAPPED, $urandom());
      case ($urandom_range(9))
        0: nb = 12'd0;
        1: nb = 12'($urandom_range(13, 4095));
        2: nb = 12'($urandom());
        default: nb = 12'($urandom_range(1, 12));
      endcase
      case ($urandom_range(9))
        0: tf = 23'd0;
        1, 2: tf = 23'($urandom_range(1, 200));
        default: tf = 23'($urandom_range(1, 48));
      endcase
      ch = 2'($urandom());
      if ($urandom_range(2) != 0) write_reg(reg_addr(REG_NUM_BINS),
                                            ($urandom() & 32'hFFFF_F000) | nb);
      if ($urandom_range(2) != 0) write_reg(reg_addr(REG_TOTAL_FRAMES),
                                            ($urandom() & 32'hFF80_0000) | tf);
      if ($urandom_range(2) != 0) write_reg(reg_addr(REG_CHANNEL_COUNT),
                                            ($urandom() & 32'hFFFF_FFFC) | ch);
      t_eff = record_frames();
      n = t_eff * $urandom_range(1, 3) + $urandom_range(0, t_eff - 1);
      if (n > 80) n = $urandom_range(20, 80);
      if ($urandom_range(3) == 0) begin
        half = n / 2;
        push_random(half);
        wait_drain();
        push_random(n - half);
      end else begin
        push_random(n);
      end
      rand_pushed += n;
    end

    wait_drain();
    repeat (END_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+rtl/core
rtl/core/apbd_pkg.sv
rtl/core/apbd_lane.sv
rtl/core/apbd_div.sv
rtl/core/audio_peak_bin_decimator.sv
tb/sv/tb_top.sv
